@@ rtl/tre_pkg.sv @@
package tre_pkg;

  localparam logic       CMD_PIXEL      = 1'b0;
  localparam logic       CMD_FLUSH      = 1'b1;
  localparam logic [7:0] HDR_REPEAT     = 8'h80;
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

  typedef struct packed {
    logic       command;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } tre_in_t;

  typedef struct packed {
    logic        has_header;
    logic [7:0]  packet_header;
    logic [1:0]  pixel_count;
    logic [31:0] first_pixel;
    logic [31:0] second_pixel;
    logic        end_of_packet;
  } tre_out_t;

  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_SINGLE,
    MODE_EQUAL,
    MODE_UNEQUAL
  } tre_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_REPEAT,
    ST_RAW_READ,
    ST_RAW_LOAD,
    ST_UPDATE
  } tre_state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic raw_read;
    logic load_repeat;
    logic load_raw;
  } tre_cmd_t;

  typedef struct packed {
    logic need_emit;
    logic emit_repeat;
    logic raw_last;
    logic out_free;
  } tre_status_t;

endpackage

@@ rtl/tre_ctrl.sv @@
module tre_ctrl import tre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tre_status_t status,
  output tre_cmd_t    cmd
);

  tre_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.need_emit) state_nxt = ST_IDLE;
        else if (status.emit_repeat) state_nxt = ST_REPEAT;
        else state_nxt = ST_RAW_READ;
      end
      ST_REPEAT: begin
        if (status.out_free) state_nxt = ST_UPDATE;
      end
      ST_RAW_READ: begin
        state_nxt = ST_RAW_LOAD;
      end
      ST_RAW_LOAD: begin
        if (status.out_free) state_nxt = status.raw_last ? ST_UPDATE : ST_RAW_READ;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECIDE: begin
        cmd.apply = !status.need_emit;
      end
      ST_REPEAT: begin
        cmd.load_repeat = status.out_free;
      end
      ST_RAW_READ: begin
        cmd.raw_read = 1'b1;
      end
      ST_RAW_LOAD: begin
        cmd.load_raw = status.out_free;
      end
      ST_UPDATE: begin
        cmd.apply = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/tre_datapath.sv @@
module tre_datapath import tre_pkg::*; #(
  parameter int MAX_PACKET = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  tre_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tre_out_t    out_data,
  input  tre_cmd_t    cmd,
  output tre_status_t status
);

  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;

  logic [31:0] buf_mem [MAX_PACKET];

  logic          with_alpha_r;
  logic          cmd_r;
  logic [31:0]   pix_r;
  tre_mode_t     mode_r, mode_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] dcount_r, dcount_nxt;
  logic [CW-1:0] idx_r;
  logic [31:0]   rd0_r, rd1_r;
  logic          out_valid_r;
  tre_out_t      out_data_r, out_data_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          eq, run_room, cnt_room, start;
  logic [CW:0]   idx_p1, idx_p2;
  logic          two;
  logic [CW-1:0] dcount_m1, run_m1;

  assign eq       = (pix_r == prev_r);
  assign run_room = (run_r < CW'(MAX_PACKET));
  assign cnt_room = (dcount_r < CW'(MAX_PACKET));

  assign status.need_emit = (cmd_r == CMD_FLUSH) ? (mode_r != MODE_EMPTY) :
                            (((mode_r == MODE_EQUAL) && !(eq && run_room)) ||
                             ((mode_r == MODE_UNEQUAL) && !(!eq && cnt_room)));

  assign idx_p1 = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (CW+1)'(2);
  assign two    = (idx_p1 < {1'b0, dcount_r});

  assign status.emit_repeat = (mode_r == MODE_EQUAL);
  assign status.raw_last    = (idx_p2 >= {1'b0, dcount_r});
  assign status.out_free    = !out_valid_r || out_ready;

  // state update for the captured transaction
  always_comb begin
    mode_nxt   = mode_r;
    prev_nxt   = prev_r;
    run_nxt    = run_r;
    dcount_nxt = dcount_r;
    wr_en      = 1'b0;
    wr_addr    = dcount_r[AW-1:0];
    start      = 1'b0;
    if (cmd_r == CMD_FLUSH) begin
      mode_nxt   = MODE_EMPTY;
      prev_nxt   = '0;
      run_nxt    = '0;
      dcount_nxt = '0;
    end else begin
      unique case (mode_r)
        MODE_EMPTY: start = 1'b1;
        MODE_SINGLE: begin
          if (eq) begin
            mode_nxt = MODE_EQUAL;
            run_nxt  = CW'(2);
          end else begin
            mode_nxt = MODE_UNEQUAL;
            prev_nxt = pix_r;
            if (cnt_room) begin
              wr_en      = 1'b1;
              dcount_nxt = dcount_r + CW'(1);
            end
          end
        end
        MODE_EQUAL: begin
          if (eq && run_room) run_nxt = run_r + CW'(1);
          else start = 1'b1;
        end
        MODE_UNEQUAL: begin
          if (!eq && cnt_room) begin
            wr_en      = 1'b1;
            dcount_nxt = dcount_r + CW'(1);
            prev_nxt   = pix_r;
          end else begin
            start = 1'b1;
          end
        end
        default: start = 1'b1;
      endcase
      if (start) begin
        mode_nxt   = MODE_SINGLE;
        prev_nxt   = pix_r;
        run_nxt    = '0;
        wr_en      = 1'b1;
        wr_addr    = '0;
        dcount_nxt = CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      with_alpha_r <= 1'b1;
      mode_r       <= MODE_EMPTY;
      prev_r       <= '0;
      run_r        <= '0;
      dcount_r     <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) with_alpha_r <= cfg_wdata;
      if (cmd.apply) begin
        mode_r   <= mode_nxt;
        prev_r   <= prev_nxt;
        run_r    <= run_nxt;
        dcount_r <= dcount_nxt;
        idx_r    <= '0;
      end else if (cmd.load_raw) begin
        idx_r <= idx_p2[CW-1:0];
      end
      if (cmd.load_repeat || cmd.load_raw) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_data.command;
      pix_r <= {with_alpha_r ? in_data.alpha : ALPHA_OPAQUE,
                in_data.red, in_data.green, in_data.blue};
    end
    if (cmd.load_repeat || cmd.load_raw) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && wr_en) buf_mem[wr_addr] <= pix_r;
    if (cmd.raw_read) begin
      rd0_r <= buf_mem[idx_r[AW-1:0]];
      rd1_r <= buf_mem[idx_p1[AW-1:0]];
    end
  end

  assign dcount_m1 = dcount_r - CW'(1);
  assign run_m1    = run_r - CW'(1);

  always_comb begin
    if (cmd.load_repeat) begin
      out_data_nxt.has_header    = 1'b1;
      out_data_nxt.packet_header = HDR_REPEAT | (8'(run_m1) & HDR_COUNT_MASK);
      out_data_nxt.pixel_count   = 2'd1;
      out_data_nxt.first_pixel   = prev_r;
      out_data_nxt.second_pixel  = '0;
      out_data_nxt.end_of_packet = 1'b1;
    end else begin
      out_data_nxt.has_header    = (idx_r == '0);
      out_data_nxt.packet_header = (idx_r == '0) ? (8'(dcount_m1) & HDR_COUNT_MASK) : 8'h00;
      out_data_nxt.pixel_count   = two ? 2'd2 : 2'd1;
      out_data_nxt.first_pixel   = rd0_r;
      out_data_nxt.second_pixel  = two ? rd1_r : 32'h0;
      out_data_nxt.end_of_packet = status.raw_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/tga_rle_pixel_encoder_core.sv @@
// TGA run-length encoder for the image data section.
// in_*  : one transaction per pixel (command 0) or end of image (command 1),
//         valid/ready handshake; the pixel is latched on acceptance.
// out_* : one transaction per result: a repeat packet in one result, a raw
//         packet as results of up to two pixels each, the first with the header.
// cfg_* : with_alpha, written on cfg_we; 0 forces alpha to 255 on capture.
// Sequence: a pixel that closes no packet passes capture and decide.
// A repeat packet adds a load and an update step; a raw packet of n pixels
// adds a buffer read and an output load step per result, ceil(n/2) results,
// then one update step; each read fetches two pixels from the pixel buffer.
// in_ready is high only while idle, so a held result blocks intake of the
// next pixel only when another result must be loaded; a stalled receiver
// holds out_data and stalls the packet sequencer until taken.
// Reset (rst_n, synchronous) empties the encoder and sets with_alpha to 1.
module tga_rle_pixel_encoder_core import tre_pkg::*; #(
  parameter int MAX_PACKET = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_ready,
  input  tre_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tre_out_t out_data
);

  tre_cmd_t    cmd;
  tre_status_t status;

  tre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tre_datapath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
